@@ rtl/soms_pkg.sv @@
package soms_pkg;

	localparam int SEQ_W       = 63;
	localparam int PAY_W       = 32;
	localparam int LANE_FLD_W  = 3;
	localparam int MAX_RESULTS = 9;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic CMD_OFFER  = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic [1:0] KIND_ITEM = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	typedef struct packed {
		logic                  cmd;
		logic [LANE_FLD_W-1:0] lane;
		logic [SEQ_W-1:0]      seq_num;
		logic [PAY_W-1:0]      payload;
	} req_item_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [LANE_FLD_W-1:0] src_lane;
		logic [SEQ_W-1:0]      out_seq;
		logic [PAY_W-1:0]      out_payload;
		logic                  last;
	} rsp_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_CHECK,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic apply;
		logic scan_start;
		logic scan_step;
		logic push_err;
		logic push_end;
		logic push_item;
	} ctrl_cmd_t;

	typedef struct packed {
		logic err;
		logic blocked;
		logic any_valid;
		logic ended;
		logic n_full;
		logic scan_done;
		logic out_free;
	} dp_sts_t;

endpackage

@@ rtl/soms_ctrl.sv @@
module soms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  soms_pkg::dp_sts_t   sts,
	output soms_pkg::ctrl_cmd_t cmd
);
	import soms_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!sts.err) state_nxt = ST_CHECK;
				else if (sts.out_free) state_nxt = ST_IDLE;
			end
			ST_CHECK: begin
				if (sts.n_full || sts.blocked) state_nxt = ST_IDLE;
				else if (sts.any_valid) state_nxt = ST_SCAN;
				else if (sts.ended || sts.out_free) state_nxt = ST_IDLE;
			end
			ST_SCAN: begin
				if (sts.scan_done) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) state_nxt = ST_CHECK;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			ST_DECIDE: begin
				if (sts.err) cmd.push_err = sts.out_free;
				else cmd.apply = 1'b1;
			end
			ST_CHECK: begin
				if (!(sts.n_full || sts.blocked)) begin
					if (sts.any_valid) cmd.scan_start = 1'b1;
					else if (!sts.ended) cmd.push_end = sts.out_free;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_EMIT: begin
				cmd.push_item = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/soms_dpath.sv @@
module soms_dpath #(
	parameter int NUM_LANES    = 8,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  soms_pkg::req_item_t req,
	input  soms_pkg::ctrl_cmd_t cmd,
	output soms_pkg::dp_sts_t   sts,
	input  logic                rsp_ready,
	output logic                rsp_valid,
	output soms_pkg::rsp_item_t rsp
);
	import soms_pkg::*;

	localparam int LANE_W     = $clog2(NUM_LANES);
	localparam int SLOT_PAY_W = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;

	// lane state lives in flops, the slot contents in a small memory
	logic [NUM_LANES-1:0]  valid_q;
	logic [NUM_LANES-1:0]  done_q;
	logic                  ended_q;
	logic [CNT_W-1:0]      n_q;
	logic [SEQ_W-1:0]      seq_mem [NUM_LANES];
	logic [SLOT_PAY_W-1:0] pay_mem [NUM_LANES];

	req_item_t             in_q;

	logic [LANE_W-1:0]     scan_idx_q;
	logic                  issued_all_q;
	logic                  rd_pend_s1;
	logic                  rd_vld_s1;
	logic                  rd_last_s1;
	logic [LANE_W-1:0]     rd_idx_s1;
	logic [SEQ_W-1:0]      rd_seq_s1;
	logic [SLOT_PAY_W-1:0] rd_pay_s1;

	logic                  best_any_q;
	logic [LANE_W-1:0]     best_idx_q;
	logic [SEQ_W-1:0]      best_seq_q;
	logic [SLOT_PAY_W-1:0] best_pay_q;

	logic                  out_valid_q;
	rsp_item_t             out_q;

	logic                  lane_ok;
	logic [LANE_W-1:0]     lidx;
	logic                  out_free;
	logic                  issue;
	logic                  take;
	logic [NUM_LANES-1:0]  best_oh;
	logic [NUM_LANES-1:0]  valid_after;
	logic                  more;

	assign lane_ok  = 32'(in_q.lane) < NUM_LANES;
	assign lidx     = LANE_W'(in_q.lane);
	assign out_free = !out_valid_q || rsp_ready;
	assign issue    = cmd.scan_step && !issued_all_q;
	assign take     = rd_pend_s1 && rd_vld_s1 && (!best_any_q || rd_seq_s1 < best_seq_q);

	assign best_oh     = {{(NUM_LANES-1){1'b0}}, 1'b1} << best_idx_q;
	assign valid_after = valid_q & ~best_oh;
	// another result follows this one within the same event
	assign more = (n_q < CNT_W'(MAX_RESULTS - 1)) && !(|(~valid_after & ~done_q))
		&& ((|valid_after) || !ended_q);

	always_comb begin
		sts.err       = !lane_ok || (in_q.cmd == CMD_OFFER && (valid_q[lidx] || done_q[lidx]));
		sts.blocked   = |(~valid_q & ~done_q);
		sts.any_valid = |valid_q;
		sts.ended     = ended_q;
		sts.n_full    = n_q == CNT_W'(MAX_RESULTS);
		sts.scan_done = rd_pend_s1 && rd_last_s1;
		sts.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			done_q       <= '0;
			ended_q      <= 1'b0;
			n_q          <= '0;
			issued_all_q <= 1'b0;
			rd_pend_s1   <= 1'b0;
			best_any_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.apply) begin
				n_q <= '0;
				if (in_q.cmd == CMD_OFFER) valid_q[lidx] <= 1'b1;
				else done_q[lidx] <= 1'b1;
			end
			if (cmd.push_item) begin
				valid_q <= valid_after;
				n_q     <= n_q + CNT_W'(1);
			end
			if (cmd.push_end) ended_q <= 1'b1;

			if (cmd.scan_start) begin
				issued_all_q <= 1'b0;
				rd_pend_s1   <= 1'b0;
				best_any_q   <= 1'b0;
			end else begin
				rd_pend_s1 <= issue;
				if (issue && scan_idx_q == LANE_W'(NUM_LANES - 1)) issued_all_q <= 1'b1;
				if (take) best_any_q <= 1'b1;
			end

			if (cmd.push_err || cmd.push_end || cmd.push_item) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) in_q <= req;
		if (cmd.apply && in_q.cmd == CMD_OFFER) begin
			seq_mem[lidx] <= in_q.seq_num;
			pay_mem[lidx] <= SLOT_PAY_W'(in_q.payload);
		end
		if (issue) begin
			rd_seq_s1 <= seq_mem[scan_idx_q];
			rd_pay_s1 <= pay_mem[scan_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			scan_idx_q <= '0;
		end else if (issue) begin
			scan_idx_q <= scan_idx_q + LANE_W'(1);
			rd_idx_s1  <= scan_idx_q;
			rd_vld_s1  <= valid_q[scan_idx_q];
			rd_last_s1 <= scan_idx_q == LANE_W'(NUM_LANES - 1);
		end
		if (take) begin
			best_idx_q <= rd_idx_s1;
			best_seq_q <= rd_seq_s1;
			best_pay_q <= rd_pay_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_err) begin
			out_q.kind        <= KIND_ERR;
			out_q.src_lane    <= in_q.lane;
			out_q.out_seq     <= '0;
			out_q.out_payload <= '0;
			out_q.last        <= 1'b1;
		end else if (cmd.push_end) begin
			out_q.kind        <= KIND_END;
			out_q.src_lane    <= '0;
			out_q.out_seq     <= '0;
			out_q.out_payload <= '0;
			out_q.last        <= 1'b1;
		end else if (cmd.push_item) begin
			out_q.kind        <= KIND_ITEM;
			out_q.src_lane    <= LANE_FLD_W'(best_idx_q);
			out_q.out_seq     <= best_seq_q;
			out_q.out_payload <= PAY_W'(best_pay_q);
			out_q.last        <= !more;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

@@ rtl/sequence_ordered_stream_merge.sv @@
// Sequence-ordered merge of up to NUM_LANES lanes into one stream.
// req channel: one event per item, either an offer (lane, seq_num, payload)
// or a finish for a lane. rsp channel: merged items in ascending sequence
// order (lowest lane on ties), one end-of-stream item once every lane is
// finished and empty, or a protocol error for a bad offer or lane.
// The last flag marks the final result caused by one event; an event may
// also cause no result at all.
// Timing: the error check is made in the cycle after acceptance, and an
// error result is pushed once the output register is free; otherwise the
// event is applied then and the end marker, if due, is pushed from the
// check state that follows. Each merged result comes from a serial scan
// of the slot memory, one lane per cycle through one sequence comparator,
// and is pushed once the output register is free.
// req_ready is high only while no event is in progress, so events are
// handled one at a time. Results sit in an output register; while the
// receiver stalls the register holds and the drain waits, and the next
// event is taken once the final result is pushed.
// Reset clears all lane flags at once; no clearing pass is needed.
module sequence_ordered_stream_merge #(
	parameter int NUM_LANES    = 8,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  soms_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output soms_pkg::rsp_item_t rsp
);
	import soms_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	soms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	soms_dpath #(
		.NUM_LANES    (NUM_LANES),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	a_push_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.push_err, cmd.push_end, cmd.push_item}))
		else $error("more than one result pushed in a cycle");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_err || cmd.push_end || cmd.push_item) |-> sts.out_free)
		else $error("result pushed over a waiting item");

	a_no_accept_mid_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> !req_ready)
		else $error("event accepted during a drain");

	a_end_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_end |=> sts.ended && !cmd.push_end)
		else $error("end marker not recorded");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import soms_pkg::*;

	localparam int LANES         = 8;
	localparam int RANDOM_EVENTS = 160;
	localparam int HOLD_CYCLES   = 150;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 40;

	// Mirrors the lane slots and works out the merged stream for each accepted item.
	class merge_tracker;
		bit             held[LANES];
		bit [SEQ_W-1:0] held_seq[LANES];
		bit [PAY_W-1:0] held_pay[LANES];
		bit             closed[LANES];
		bit             ended;
		rsp_item_t      merge_due[$];
		int             faults;
		int             n_merged;
		int             n_ends;
		int             n_errs;

		function void take_event(req_item_t ev);
			rsp_item_t batch[$];
			rsp_item_t r;
			int        best;
			bit        blocked;
			bit        any;
			bit        done;
			r = '0;
			if (ev.lane >= LANES ||
			    (ev.cmd == CMD_OFFER && (held[ev.lane] || closed[ev.lane]))) begin
				r.kind = KIND_ERR;
				r.src_lane = ev.lane;
				r.last = 1'b1;
				merge_due.push_back(r);
				return;
			end
			if (ev.cmd == CMD_OFFER) begin
				held[ev.lane] = 1'b1;
				held_seq[ev.lane] = ev.seq_num;
				held_pay[ev.lane] = ev.payload;
			end else begin
				closed[ev.lane] = 1'b1;
			end
			done = 1'b0;
			while (!done && batch.size() < MAX_RESULTS) begin
				blocked = 1'b0;
				any = 1'b0;
				best = 0;
				for (int i = 0; i < LANES; i++) begin
					if (!held[i]) begin
						// an open lane with nothing held stalls the whole merge
						if (!closed[i])
							blocked = 1'b1;
					end else begin
						if (!any || held_seq[i] < held_seq[best])
							best = i;
						any = 1'b1;
					end
				end
				r = '0;
				if (blocked) begin
					done = 1'b1;
				end else if (!any) begin
					if (!ended) begin
						ended = 1'b1;
						r.kind = KIND_END;
						batch.push_back(r);
					end
					done = 1'b1;
				end else begin
					r.kind = KIND_ITEM;
					r.src_lane = LANE_FLD_W'(best);
					r.out_seq = held_seq[best];
					r.out_payload = held_pay[best];
					batch.push_back(r);
					held[best] = 1'b0;
				end
			end
			if (batch.size() > 0)
				batch[batch.size() - 1].last = 1'b1;
			foreach (batch[k])
				merge_due.push_back(batch[k]);
		endfunction

		function void cmp_field(string fld, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, fld, want, got);
				faults++;
			end
		endfunction

		function void match_result(rsp_item_t got);
			rsp_item_t want;
			if (merge_due.size() == 0) begin
				$display("%0t: result with nothing due: expected none, actual %h", $time, got);
				faults++;
				return;
			end
			want = merge_due.pop_front();
			case (want.kind)
				KIND_ITEM: n_merged++;
				KIND_END:  n_ends++;
				default:   n_errs++;
			endcase
			cmp_field("kind", want.kind, got.kind);
			cmp_field("src_lane", want.src_lane, got.src_lane);
			cmp_field("out_seq", want.out_seq, got.out_seq);
			cmp_field("out_payload", want.out_payload, got.out_payload);
			cmp_field("last", want.last, got.last);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_item_t        req = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_item_t        rsp;
	bit               calm = 1'b0;
	bit               hold_req = 1'b0;
	int               quiet_cycles = 0;
	int               n_events = 0;
	logic [SEQ_W-1:0] seq_ramp = '0;
	merge_tracker     trk = new;

	sequence_ordered_stream_merge #(
		.NUM_LANES    (LANES),
		.PAYLOAD_BITS (PAY_W)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// mix of wide random values, small values that tie, a rising ramp and the extremes
	function automatic logic [SEQ_W-1:0] rand_seq();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return w[SEQ_W-1:0];
			1: return SEQ_W'($urandom_range(0, 7));
			2: begin
				seq_ramp = seq_ramp + SEQ_W'($urandom_range(1, 3));
				return seq_ramp;
			end
			default: return w[0] ? '1 : '0;
		endcase
	endfunction

	task automatic send_event(req_item_t ev);
		req <= ev;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_ready !== 1'b1);
		trk.take_event(ev);
		n_events++;
		if (!calm && $urandom_range(0, 2) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic offer(int lane, logic [SEQ_W-1:0] seq, logic [PAY_W-1:0] pay);
		req_item_t ev;
		ev.cmd = CMD_OFFER;
		ev.lane = LANE_FLD_W'(lane);
		ev.seq_num = seq;
		ev.payload = pay;
		send_event(ev);
	endtask

	task automatic finish_lane(int lane);
		req_item_t ev;
		ev.cmd = CMD_FINISH;
		ev.lane = LANE_FLD_W'(lane);
		ev.seq_num = rand_seq();
		ev.payload = $urandom;
		send_event(ev);
	endtask

	always @(posedge clk)
		if (arst_n && rsp_valid === 1'b1 && rsp_ready)
			trk.match_result(rsp);

	always @(posedge clk) begin
		if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	// result side: short random stalls, and one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_ready <= 1'b1;
			end else if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				stall_left = $urandom_range(0, 3);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		int open[$];
		int roll;
		int spare;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every lane, with extremes and ties on lanes 0 to 3
		offer(0, '1, '1);
		offer(0, 63'd5, '0);              // lane already holds an item
		offer(1, '0, '0);
		offer(2, '0, 32'h5555_5555);      // ties lane 1 at zero
		offer(3, '1, 32'hAAAA_AAAA);      // ties lane 0 at the top
		for (int i = 4; i < LANES; i++)
			offer(i, rand_seq(), $urandom);
		offer(7, 63'd9, 32'h1234_5678);  // occupied
		offer(1, '0, 32'h1);             // tie again, lower lane wins
		offer(1, 63'd1, 32'h2);
		offer(2, '1, '1);

		for (int k = 0; k < RANDOM_EVENTS; k++) begin
			calm = (k >= RANDOM_EVENTS - 30) || ((k / 25) % 3 == 2);
			if (k == 40)
				hold_req = 1'b1;
			open.delete();
			for (int i = 0; i < LANES; i++)
				if (!trk.held[i] && !trk.closed[i])
					open.push_back(i);
			roll = $urandom_range(0, 99);
			if (k >= RANDOM_EVENTS - 50 && roll < 8)
				finish_lane($urandom_range(0, LANES - 1));
			else if (open.size() > 0 && roll < 88)
				offer(open[$urandom_range(0, open.size() - 1)], rand_seq(), $urandom);
			else
				offer($urandom_range(0, LANES - 1), rand_seq(), $urandom);
		end

		// close every lane but one empty open lane, then release the lot at once
		calm = 1'b1;
		spare = -1;
		for (int i = 0; i < LANES; i++)
			if (!trk.held[i] && !trk.closed[i] && spare < 0)
				spare = i;
		for (int i = 0; i < LANES; i++)
			if (!trk.closed[i] && i != spare)
				finish_lane(i);
		if (spare >= 0) begin
			offer(spare, '1, $urandom);
			finish_lane(spare);
		end
		finish_lane(0);                  // after end of stream: nothing comes out
		offer($urandom_range(0, LANES - 1), rand_seq(), $urandom);
		req_valid <= 1'b0;

		while (trk.merge_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d events; checked %0d merged items, %0d end markers, %0d errors.",
			n_events, trk.n_merged, trk.n_ends, trk.n_errs);
		$display("Random stalls on both sides, one %0d-cycle output hold-off, quiet tail.",
			HOLD_CYCLES);
		if (trk.faults == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
